// File: rtl/multivariate_polynomial_evaluator_core_defines.svh
// Assertion macros shared by the polynomial evaluator RTL.
// No dependencies; included by the files that carry checks.
`ifndef MULTIVARIATE_POLYNOMIAL_EVALUATOR_CORE_DEFINES_SVH
`define MULTIVARIATE_POLYNOMIAL_EVALUATOR_CORE_DEFINES_SVH

// Clocked check, masked while reset is low.
`define MPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also runs during reset.
`define MPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/mpe_pkg.sv
// Shared widths, codes and control structs for the polynomial evaluator.
// No dependencies.
`default_nettype none

package mpe_pkg;

  localparam int COEF_W = 16;
  localparam int BASE_W = 16;
  localparam int EXP_W  = 4;
  localparam int MAG_W  = 64;
  localparam int HALF_W = 32;
  localparam int PROD_W = HALF_W + BASE_W;
  localparam int FULL_W = MAG_W + BASE_W;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_Z = 2'd2;

  // Variable select codes
  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;

  localparam logic [MAG_W-1:0] LIMIT_POS = {1'b0, {(MAG_W-1){1'b1}}};
  localparam logic [MAG_W-1:0] LIMIT_NEG = {1'b1, {(MAG_W-1){1'b0}}};

  // Control of the shared multiplier
  typedef struct packed {
    logic load;  // load magnitude, clear overflow
    logic lo;    // low half product
    logic hi;    // high half product, combine and saturate
  } mul_ctrl_t;

  // Control of the accumulator
  typedef struct packed {
    logic valid;
    logic last;
    logic zero;
    logic neg;
  } acc_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/mpe_sat_mul.sv
// Shared saturating multiplier: 64-bit magnitude times 16-bit base in a low-half
// step and a high-half step on one 32x16 multiplier. Depends on mpe_pkg and the defines header.
`default_nettype none
`include "multivariate_polynomial_evaluator_core_defines.svh"

module mpe_sat_mul
  import mpe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mul_ctrl_t         ctrl_i,
  input  wire logic [MAG_W-1:0]  load_mag_i,
  input  wire logic [BASE_W-1:0] base_i,
  input  wire logic              neg_i,
  output logic      [MAG_W-1:0]  mag_o,
  output logic                   povf_o
);

  logic [MAG_W-1:0]  mag_r;
  logic [PROD_W-1:0] lo_r;
  logic              povf_r;
  logic [HALF_W-1:0] mul_a;
  logic [PROD_W-1:0] prod;
  logic [FULL_W-1:0] full;
  logic [MAG_W-1:0]  limit;
  logic              over;

  // One multiplier, operand half chosen by phase
  assign mul_a = ctrl_i.hi ? mag_r[MAG_W-1:HALF_W] : mag_r[HALF_W-1:0];
  assign prod  = PROD_W'(mul_a) * PROD_W'(base_i);

  // Recombine halves and clamp to the sign's limit
  assign full  = {prod, {HALF_W{1'b0}}} + {{(FULL_W-PROD_W){1'b0}}, lo_r};
  assign limit = neg_i ? LIMIT_NEG : LIMIT_POS;
  assign over  = full > {{BASE_W{1'b0}}, limit};

  always_ff @(posedge clk) begin
    if (ctrl_i.load) begin
      mag_r <= load_mag_i;
    end else if (ctrl_i.hi) begin
      mag_r <= over ? limit : full[MAG_W-1:0];
    end
    if (ctrl_i.lo) begin
      lo_r <= prod;
    end
  end

  // Sticky overflow for the current term
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      povf_r <= 1'b0;
    end else if (ctrl_i.load) begin
      povf_r <= 1'b0;
    end else if (ctrl_i.hi && over) begin
      povf_r <= 1'b1;
    end
  end

  assign mag_o  = mag_r;
  assign povf_o = povf_r;

  `MPE_ASSERT(a_hi_after_lo, ctrl_i.hi |-> $past(ctrl_i.lo), "high half without low half")

endmodule

`default_nettype wire

// File: rtl/mpe_accum.sv
// Saturating 64-bit running sum and result register.
// Depends on mpe_pkg and the defines header.
`default_nettype none
`include "multivariate_polynomial_evaluator_core_defines.svh"

module mpe_accum
  import mpe_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire acc_ctrl_t        acc_i,
  input  wire logic [MAG_W-1:0] mag_i,
  input  wire logic             povf_i,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic signed [MAG_W-1:0] out_poly_value,
  output logic                  out_overflowed
);

  logic [MAG_W-1:0] sum_r;
  logic             ovf_seen_r;
  logic             out_valid_r;
  logic [MAG_W-1:0] poly_r;
  logic             ovfl_r;
  logic [MAG_W-1:0] term;
  logic [MAG_W:0]   sum_ext;
  logic             sum_ovf;
  logic [MAG_W-1:0] sum_nxt;
  logic             ovf_nxt;

  // Signed term; negating 2^63 gives the most negative value as needed
  always_comb begin
    if (acc_i.zero) begin
      term = '0;
    end else if (acc_i.neg) begin
      term = ~mag_i + MAG_W'(1);
    end else begin
      term = mag_i;
    end
  end

  // Saturating add
  assign sum_ext = {sum_r[MAG_W-1], sum_r} + {term[MAG_W-1], term};
  assign sum_ovf = sum_ext[MAG_W] != sum_ext[MAG_W-1];
  assign sum_nxt = sum_ovf ? (sum_ext[MAG_W] ? LIMIT_NEG : LIMIT_POS) : sum_ext[MAG_W-1:0];
  assign ovf_nxt = ovf_seen_r | sum_ovf | (povf_i & ~acc_i.zero);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      ovf_seen_r <= 1'b0;
    end else if (acc_i.valid) begin
      if (acc_i.last) begin
        sum_r      <= '0;
        ovf_seen_r <= 1'b0;
      end else begin
        sum_r      <= sum_nxt;
        ovf_seen_r <= ovf_nxt;
      end
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc_i.valid && acc_i.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_i.valid && acc_i.last) begin
      poly_r <= sum_nxt;
      ovfl_r <= ovf_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_poly_value = signed'(poly_r);
  assign out_overflowed = ovfl_r;

  `MPE_ASSERT(a_no_overwrite,
              !(acc_i.valid && acc_i.last && out_valid_r && !out_ready),
              "result word overwritten before it was taken")
  `MPE_ASSERT(a_clear_after_last,
              (acc_i.valid && acc_i.last) |=> (sum_r == '0 && !ovf_seen_r && out_valid_r),
              "sum not cleared or result not posted after last term")

endmodule

`default_nettype wire

// File: rtl/multivariate_polynomial_evaluator_core.sv
// Multivariate polynomial evaluator: top level, term sequencer and point registers.
// Depends on mpe_pkg, mpe_sat_mul, mpe_accum and the defines header.
//
// Usage:
//   Write point_x/y/z through cfg_we/cfg_index/cfg_data while idle; index 3
//   is ignored. Each input word on in_* is one term: coefficient, exponents
//   and a last-term flag. Exponents above MAX_EXPONENT are clamped.
//   Each term is multiplied out on one shared 32x16 multiplier: every factor
//   of a base takes a low-half step, then a high-half step with saturation.
//   in_ready is low while a term occupies the block. Terms with a zero factor
//   or with all exponents zero skip the multiplier. After the last term,
//   out_valid rises and the result word is held until out_ready. Non-last
//   terms keep flowing while a result waits; a last term waits in the
//   accumulate step until the result register is free.
//   Synchronous reset (rst_n low) clears the points, the running sum, the
//   overflow flag and the result valid flag.
`default_nettype none
`include "multivariate_polynomial_evaluator_core_defines.svh"

module multivariate_polynomial_evaluator_core
  import mpe_pkg::*;
#(
  parameter int MAX_EXPONENT = 15
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // configuration
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [BASE_W-1:0]        cfg_data,
  // term input
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [COEF_W-1:0] in_coefficient,
  input  wire logic [EXP_W-1:0]         in_exp_x,
  input  wire logic [EXP_W-1:0]         in_exp_y,
  input  wire logic [EXP_W-1:0]         in_exp_z,
  input  wire logic                     in_last_term,
  // result
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [MAG_W-1:0]       out_poly_value,
  output logic                          out_overflowed
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LO   = 2'd1;
  localparam logic [1:0] S_HI   = 2'd2;
  localparam logic [1:0] S_ACC  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        sel_r, sel_nxt;
  logic [EXP_W-1:0]  cnt_x_r, cnt_y_r, cnt_z_r;
  logic [EXP_W-1:0]  cnt_x_nxt, cnt_y_nxt, cnt_z_nxt;
  logic              last_r, zero_r, neg_r;
  logic [BASE_W-1:0] point_x_r, point_y_r, point_z_r;

  logic [EXP_W-1:0]  ex_c, ey_c, ez_c;
  logic [EXP_W-1:0]  dx, dy, dz;
  logic              zero_c, neg_c, in_fire, acc_go;
  logic [MAG_W-1:0]  coef_mag;
  logic [BASE_W-1:0] base;
  logic [MAG_W-1:0]  mag;
  logic              povf;
  mul_ctrl_t         mul_ctrl;
  acc_ctrl_t         acc_ctrl;

  function automatic logic [EXP_W-1:0] clamp_exp(input logic [EXP_W-1:0] e);
    clamp_exp = ({2'b00, e} > 6'(MAX_EXPONENT)) ? EXP_W'(MAX_EXPONENT) : e;
  endfunction

  function automatic logic [BASE_W-1:0] abs16(input logic [BASE_W-1:0] v);
    abs16 = v[BASE_W-1] ? (~v + BASE_W'(1)) : v;
  endfunction

  // First variable with factors still to apply, x before y before z
  function automatic logic [1:0] pick(input logic [EXP_W-1:0] cx,
                                      input logic [EXP_W-1:0] cy);
    if (cx != '0) begin
      pick = SEL_X;
    end else if (cy != '0) begin
      pick = SEL_Y;
    end else begin
      pick = SEL_Z;
    end
  endfunction

  // Point registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_x_r <= '0;
      point_y_r <= '0;
      point_z_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_POINT_X) point_x_r <= cfg_data;
      if (cfg_index == CFG_POINT_Y) point_y_r <= cfg_data;
      if (cfg_index == CFG_POINT_Z) point_z_r <= cfg_data;
    end
  end

  // Term decode at acceptance
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign ex_c     = clamp_exp(in_exp_x);
  assign ey_c     = clamp_exp(in_exp_y);
  assign ez_c     = clamp_exp(in_exp_z);
  assign zero_c   = (in_coefficient == '0) ||
                    (point_x_r == '0 && ex_c != '0) ||
                    (point_y_r == '0 && ey_c != '0) ||
                    (point_z_r == '0 && ez_c != '0);
  assign neg_c    = in_coefficient[COEF_W-1] ^ (point_x_r[BASE_W-1] & ex_c[0]) ^
                    (point_y_r[BASE_W-1] & ey_c[0]) ^ (point_z_r[BASE_W-1] & ez_c[0]);
  assign coef_mag = {{(MAG_W-BASE_W){1'b0}}, abs16(in_coefficient)};

  // Counts after one factor of the selected variable
  assign dx = (sel_r == SEL_X) ? cnt_x_r - EXP_W'(1) : cnt_x_r;
  assign dy = (sel_r == SEL_Y) ? cnt_y_r - EXP_W'(1) : cnt_y_r;
  assign dz = (sel_r == SEL_Z) ? cnt_z_r - EXP_W'(1) : cnt_z_r;

  // Last term may only post when the result register is free
  assign acc_go = !(last_r && out_valid && !out_ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cnt_x_nxt = cnt_x_r;
    cnt_y_nxt = cnt_y_r;
    cnt_z_nxt = cnt_z_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cnt_x_nxt = ex_c;
          cnt_y_nxt = ey_c;
          cnt_z_nxt = ez_c;
          sel_nxt   = pick(ex_c, ey_c);
          if (zero_c || (ex_c == '0 && ey_c == '0 && ez_c == '0)) begin
            state_nxt = S_ACC;
          end else begin
            state_nxt = S_LO;
          end
        end
      end
      S_LO: begin
        state_nxt = S_HI;
      end
      S_HI: begin
        cnt_x_nxt = dx;
        cnt_y_nxt = dy;
        cnt_z_nxt = dz;
        sel_nxt   = pick(dx, dy);
        if (dx == '0 && dy == '0 && dz == '0) begin
          state_nxt = S_ACC;
        end else begin
          state_nxt = S_LO;
        end
      end
      S_ACC: begin
        if (acc_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= SEL_X;
      cnt_x_r <= '0;
      cnt_y_r <= '0;
      cnt_z_r <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      cnt_x_r <= cnt_x_nxt;
      cnt_y_r <= cnt_y_nxt;
      cnt_z_r <= cnt_z_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      last_r <= in_last_term;
      zero_r <= zero_c;
      neg_r  <= neg_c;
    end
  end

  // Base magnitude for the current factor
  always_comb begin
    unique case (sel_r)
      SEL_X:   base = abs16(point_x_r);
      SEL_Y:   base = abs16(point_y_r);
      default: base = abs16(point_z_r);
    endcase
  end

  assign mul_ctrl.load = in_fire;
  assign mul_ctrl.lo   = (state_r == S_LO);
  assign mul_ctrl.hi   = (state_r == S_HI);

  assign acc_ctrl.valid = (state_r == S_ACC) && acc_go;
  assign acc_ctrl.last  = last_r;
  assign acc_ctrl.zero  = zero_r;
  assign acc_ctrl.neg   = neg_r;

  mpe_sat_mul u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl_i     (mul_ctrl),
    .load_mag_i (coef_mag),
    .base_i     (base),
    .neg_i      (neg_r),
    .mag_o      (mag),
    .povf_o     (povf)
  );

  mpe_accum u_acc (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc_i          (acc_ctrl),
    .mag_i          (mag),
    .povf_i         (povf),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_poly_value (out_poly_value),
    .out_overflowed (out_overflowed)
  );

  `MPE_ASSERT(a_busy_after_accept, in_fire |=> !in_ready, "term accepted while busy")
  `MPE_ASSERT_ALWAYS(a_mul_idle_when_ready,
                     in_ready |-> (!mul_ctrl.lo && !mul_ctrl.hi && !acc_ctrl.valid),
                     "datapath active while ready for a term")

endmodule

`default_nettype wire

// File: tb/sv/multivariate_polynomial_evaluator_core_test.sv
// Self-checking testbench for the sparse three-variable polynomial evaluator.
// Depends on mpe_pkg and the multivariate_polynomial_evaluator_core RTL.
// Terms are driven as words, predicted in saturating integer arithmetic and checked.
`default_nettype none

module multivariate_polynomial_evaluator_core_test;
  import mpe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_EXP       = 15;
  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_TERMS   = 44;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic [EXP_W-1:0]         exp_x;
    logic [EXP_W-1:0]         exp_y;
    logic [EXP_W-1:0]         exp_z;
    logic                     last;
  } term_t;

  typedef struct packed {
    logic signed [MAG_W-1:0] value;
    logic                    overflowed;
  } poly_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [BASE_W-1:0]        cfg_data = '0;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [COEF_W-1:0] in_coefficient = '0;
  logic [EXP_W-1:0]         in_exp_x = '0;
  logic [EXP_W-1:0]         in_exp_y = '0;
  logic [EXP_W-1:0]         in_exp_z = '0;
  logic                     in_last_term = 1'b0;

  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [MAG_W-1:0]  out_poly_value;
  logic                     out_overflowed;

  // Shadow of the evaluation point and the accumulator
  logic signed [BASE_W-1:0] point_model [3];
  logic signed [MAG_W-1:0]  running_total = '0;
  logic                     saw_overflow = 1'b0;

  term_t        pending_terms [$];
  poly_result_t poly_values_due [$];
  term_t        held_term;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int stall_cycles = 0;

  multivariate_polynomial_evaluator_core #(
    .MAX_EXPONENT(MAX_EXP)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_coefficient(in_coefficient),
    .in_exp_x      (in_exp_x),
    .in_exp_y      (in_exp_y),
    .in_exp_z      (in_exp_z),
    .in_last_term  (in_last_term),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_poly_value(out_poly_value),
    .out_overflowed(out_overflowed)
  );

  initial forever #2 clk = ~clk;

  function automatic logic [EXP_W-1:0] clamp_power(input logic [EXP_W-1:0] e);
    return (int'(e) > MAX_EXP) ? EXP_W'(MAX_EXP) : e;
  endfunction

  // Add one term to the running sum; a last term closes the polynomial
  task automatic accumulate_term(input term_t t);
    logic [EXP_W-1:0]        pw [3];
    logic [COEF_W-1:0]       coef_mag;
    logic [BASE_W-1:0]       base_mag;
    logic [MAG_W-1:0]        limit;
    logic [MAG_W-1:0]        mag;
    logic [FULL_W-1:0]       prod;
    logic signed [MAG_W-1:0] term_val;
    logic signed [MAG_W:0]   total;
    logic                    neg;
    logic                    zero_term;
    int                      v;
    int                      k;
    pw[0] = clamp_power(t.exp_x);
    pw[1] = clamp_power(t.exp_y);
    pw[2] = clamp_power(t.exp_z);
    term_val = '0;
    // zero coefficient, or a zero base raised to a nonzero power
    zero_term = (t.coef == 0);
    for (v = 0; v < 3; v++)
      if (point_model[v] == 0 && pw[v] != 0) zero_term = 1'b1;
    if (!zero_term) begin
      neg = t.coef[COEF_W-1];
      for (v = 0; v < 3; v++)
        if (point_model[v][BASE_W-1] && pw[v][0]) neg = !neg;
      limit = neg ? LIMIT_NEG : LIMIT_POS;
      coef_mag = t.coef[COEF_W-1] ? (~t.coef + 1'b1) : t.coef;
      mag = {{(MAG_W-COEF_W){1'b0}}, coef_mag};
      // repeated multiply, magnitude clamps at the signed limit
      for (v = 0; v < 3; v++) begin
        base_mag = point_model[v][BASE_W-1] ? (~point_model[v] + 1'b1) : point_model[v];
        for (k = 0; k < int'(pw[v]); k++) begin
          prod = {{BASE_W{1'b0}}, mag} * {{MAG_W{1'b0}}, base_mag};
          if (prod > {{BASE_W{1'b0}}, limit}) begin
            mag = limit;
            saw_overflow = 1'b1;
          end else begin
            mag = prod[MAG_W-1:0];
          end
        end
      end
      term_val = neg ? -mag : mag;
    end
    // saturating 64-bit sum
    total = {running_total[MAG_W-1], running_total} + {term_val[MAG_W-1], term_val};
    if (total[MAG_W] != total[MAG_W-1]) begin
      running_total = total[MAG_W] ? LIMIT_NEG : LIMIT_POS;
      saw_overflow = 1'b1;
    end else begin
      running_total = total[MAG_W-1:0];
    end
    if (t.last) begin
      poly_values_due.push_back({running_total, saw_overflow});
      running_total = '0;
      saw_overflow = 1'b0;
    end
  endtask

  // Input driver: new word only when the slot is empty or just accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) accumulate_term(held_term);
      if (!in_valid || in_ready) begin
        if (pending_terms.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          held_term = pending_terms.pop_front();
          in_valid <= 1'b1;
          in_coefficient <= held_term.coef;
          in_exp_x <= held_term.exp_x;
          in_exp_y <= held_term.exp_y;
          in_exp_z <= held_term.exp_z;
          in_last_term <= held_term.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each word against the oldest prediction
  always @(posedge clk) begin : result_check
    poly_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (poly_values_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0d ovf %0b",
                   $time, out_poly_value, out_overflowed);
          mismatch_count++;
        end else begin
          want = poly_values_due.pop_front();
          if (out_poly_value !== want.value) begin
            $display("%0t: wrong poly_value, expected %0d, got %0d",
                     $time, want.value, out_poly_value);
            mismatch_count++;
          end
          if (out_overflowed !== want.overflowed) begin
            $display("%0t: wrong overflowed, expected %0b, got %0b",
                     $time, want.overflowed, out_overflowed);
            mismatch_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("multivariate_polynomial_evaluator_core: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_point(input logic [CFG_IDX_W-1:0] idx, input logic [BASE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx != CFG_UNUSED) point_model[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_term(input logic [COEF_W-1:0] coef, input logic [EXP_W-1:0] ex,
                          input logic [EXP_W-1:0] ey, input logic [EXP_W-1:0] ez,
                          input logic last);
    pending_terms.push_back({coef, ex, ey, ez, last});
  endtask

  // Hold the sender until every result is in and the last term has finished
  task automatic drain_results();
    while (pending_terms.size() != 0 || in_valid || poly_values_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [BASE_W-1:0] random_point();
    case ($urandom_range(3))
      0:       return BASE_W'($urandom_range(4)) - 16'd2;
      1:       return BASE_W'($urandom_range(16)) - 16'd8;
      2:       return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      default: return BASE_W'($urandom());
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] random_coef();
    case ($urandom_range(9))
      0:       return '0;
      1:       return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      2:       return $urandom_range(1) ? 16'hFFFF : 16'h0001;
      3, 4, 5: return COEF_W'($urandom_range(16)) - 16'd8;
      default: return COEF_W'($urandom());
    endcase
  endfunction

  // mostly short powers so the block is not always saturated
  function automatic logic [EXP_W-1:0] random_power();
    return ($urandom_range(9) < 7) ? EXP_W'($urandom_range(3)) : EXP_W'($urandom_range(15));
  endfunction

  task automatic queue_polynomials(input int n_terms);
    int left;
    int span;
    int j;
    left = n_terms;
    while (left > 0) begin
      span = $urandom_range(8, 1);
      if (span > left) span = left;
      for (j = 0; j < span; j++)
        add_term(random_coef(), random_power(), random_power(), random_power(), j == span - 1);
      left -= span;
    end
  endtask

  // Stimulus sequence
  initial begin
    int mode;
    int ph;
    point_model[0] = '0;
    point_model[1] = '0;
    point_model[2] = '0;
    send_idle_pct = 28;
    recv_idle_pct = 60;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // point at reset value: zero power of zero, zero bases, zero coefficient
    add_term(16'd5, 4'd0, 4'd0, 4'd0, 1'b0);
    add_term(16'd7, 4'd3, 4'd0, 4'd0, 1'b0);
    add_term(16'd0, 4'd15, 4'd15, 4'd15, 1'b1);
    add_term(16'h8000, 4'd0, 4'd0, 4'd0, 1'b1);
    drain_results();

    // extreme point, unused index must be ignored
    write_point(CFG_POINT_X, 16'h8000);
    write_point(CFG_POINT_Y, 16'h7FFF);
    write_point(CFG_POINT_Z, 16'hFFFF);
    write_point(CFG_UNUSED, 16'h1234);
    // exact most-negative term, then negative sum overflow
    add_term(-16'sd8, 4'd4, 4'd0, 4'd0, 1'b0);
    add_term(-16'sd1, 4'd0, 4'd0, 4'd0, 1'b1);
    // positive product overflow
    add_term(16'd8, 4'd4, 4'd0, 4'd0, 1'b1);
    // negative and positive product clamps cancel
    add_term(16'd1, 4'd15, 4'd0, 4'd0, 1'b0);
    add_term(16'h7FFF, 4'd0, 4'd15, 4'd0, 1'b0);
    add_term(16'd1, 4'd0, 4'd0, 4'd1, 1'b1);
    // positive sum overflow
    add_term(16'h7FFF, 4'd0, 4'd15, 4'd0, 1'b0);
    add_term(16'd1, 4'd0, 4'd0, 4'd0, 1'b1);
    // all powers at the maximum, then smaller powers
    add_term(16'h8000, 4'd15, 4'd15, 4'd15, 1'b1);
    add_term(16'd3, 4'd0, 4'd0, 4'd14, 1'b1);
    add_term(-16'sd1, 4'd1, 4'd1, 4'd1, 1'b1);
    drain_results();

    // random polynomials over three idle profiles
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0:       begin send_idle_pct = 28; recv_idle_pct = 60; end
        1:       begin send_idle_pct = 60; recv_idle_pct = 28; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (ph = 0; ph < 5; ph++) begin
        write_point(CFG_POINT_X, random_point());
        write_point(CFG_POINT_Y, random_point());
        write_point(CFG_POINT_Z, random_point());
        queue_polynomials(PHASE_TERMS);
        drain_results();
      end
    end

    if (mismatch_count == 0) begin
      $display("multivariate_polynomial_evaluator_core: match");
    end else begin
      $display("multivariate_polynomial_evaluator_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
